// ----- rtl/bpfa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the bitmap page frame allocator: sizes, operation codes,
// engine states and the control structs between top level and engine.
// No dependencies.
package bpfa_pkg;

   localparam int NUM_FRAMES  = 32768;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = NUM_FRAMES / WORD_BITS;
   localparam int FRAME_SHIFT = 12;
   localparam int ADDR_W      = 32;
   localparam int PAGE_W      = ADDR_W - FRAME_SHIFT;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WIDX_W      = $clog2(MAP_WORDS);
   localparam int FIDX_W      = $clog2(NUM_FRAMES);
   localparam int COUNT_W     = 16;
   localparam int KB_W        = 18;
   localparam int OP_W        = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [CSR_ADDR_W-3:0] CSR_MEMORY_SIZE_KB = '0;

   typedef enum logic [OP_W-1:0] {
      OP_INIT        = 3'd0,
      OP_ALLOC       = 3'd1,
      OP_FREE        = 3'd2,
      OP_REGION_FREE = 3'd3,
      OP_REGION_USED = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                start;
      logic                take;
      op_type              op;
      logic [PAGE_W-1:0]   frame;
      logic [PAGE_W-1:0]   count;
      logic [COUNT_W-1:0]  max_frames;
   } cmd_type;

   typedef struct packed {
      logic                idle;
      logic                done;
      logic                ok;
      logic [FIDX_W-1:0]   frame;
      logic [COUNT_W-1:0]  used;
   } sts_type;

endpackage

// ----- rtl/bpfa_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the page frame allocator.
// Depends on bpfa_pkg.
interface bpfa_req_if
   import bpfa_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ADDR_W-1:0] address;
   logic [ADDR_W-1:0] length;

   modport source (output valid, output op, output address, output length, input ready);
   modport sink   (input valid, input op, input address, input length, output ready);
endinterface

interface bpfa_rsp_if
   import bpfa_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  frame_address;
   logic               ok;
   logic [COUNT_W-1:0] used_frames;
   logic [COUNT_W-1:0] free_frames;

   modport source (output valid, output frame_address, output ok, output used_frames,
                   output free_frames, input ready);
   modport sink   (input valid, input frame_address, input ok, input used_frames,
                   input free_frames, output ready);
endinterface

// ----- rtl/bpfa_engine.sv -----
`timescale 1ns / 1ps
// Map engine: frame bitmap memory, fill sweep, word walker for alloc, free
// and region operations, and the used-frame counter. Depends on bpfa_pkg.
module bpfa_engine
   import bpfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts
);

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 we;
   logic [WIDX_W-1:0]    waddr;
   logic [WORD_BITS-1:0] wdata;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic                issue_ff, issue_in;
   logic                dv_ff, dv_in;
   logic [WIDX_W-1:0]   addr_ff, addr_in;
   logic [WIDX_W-1:0]   didx_ff, didx_in;
   logic [WIDX_W-1:0]   whi_ff, whi_in;
   logic [FIDX_W-1:0]   lo_ff, lo_in;
   logic [FIDX_W-1:0]   last_ff, last_in;
   logic                fix_ff, fix_in;
   logic [COUNT_W-1:0]  maxf_ff, maxf_in;
   logic [COUNT_W-1:0]  used_ff, used_in;
   logic                ok_ff, ok_in;
   logic [FIDX_W-1:0]   hit_ff, hit_in;

   logic [COUNT_W-1:0]  words;
   logic                alloc_go;
   logic                frame_ok;
   logic                region_go;
   logic [PAGE_W:0]     sum_m1;
   logic [FIDX_W-1:0]   last_start;
   logic                fill_end;
   logic                word_full;
   logic [BIT_W-1:0]    zbit;
   logic [BIT_W-1:0]    lo_bit;
   logic [BIT_W-1:0]    hi_bit;
   logic [WORD_BITS-1:0] mask;
   logic [BIT_W:0]      nbits;
   logic [COUNT_W:0]    up_sum;
   logic                last_w;
   logic                hit;
   logic                do_fix;
   logic                set_mode;

   // bitmap memory, read data forwarded when read and write hit one word
   always_ff @(posedge clock) begin
      if (we) begin
         map_mem[waddr] <= wdata;
      end
      rdata_ff <= (we && waddr == addr_ff) ? wdata : map_mem[addr_ff];
   end

   assign words      = cmd.max_frames >> BIT_W;
   assign alloc_go   = (used_ff < cmd.max_frames) && (words != '0);
   assign frame_ok   = {1'b0, cmd.frame} < (PAGE_W+1)'(NUM_FRAMES);
   assign region_go  = frame_ok && (cmd.count != '0);
   assign sum_m1     = {1'b0, cmd.frame} + {1'b0, cmd.count} - (PAGE_W+1)'(1);
   assign last_start = (sum_m1 >= (PAGE_W+1)'(NUM_FRAMES)) ? FIDX_W'(NUM_FRAMES - 1)
                                                            : sum_m1[FIDX_W-1:0];
   assign fill_end   = addr_ff == WIDX_W'(MAP_WORDS - 1);

   assign word_full = &rdata_ff;
   always_comb begin
      zbit = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (!rdata_ff[j]) zbit = BIT_W'(j);
      end
   end

   assign lo_bit  = (didx_ff == lo_ff[FIDX_W-1:BIT_W]) ? lo_ff[BIT_W-1:0] : '0;
   assign hi_bit  = (didx_ff == whi_ff) ? last_ff[BIT_W-1:0] : '1;
   assign mask    = ({WORD_BITS{1'b1}} << lo_bit)
                  & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
   assign nbits   = {1'b0, hi_bit} - {1'b0, lo_bit} + (BIT_W+1)'(1);
   assign up_sum  = {1'b0, used_ff} + (COUNT_W+1)'(nbits);
   assign set_mode = fix_ff || (op_ff == OP_REGION_USED);

   assign last_w = dv_ff && (didx_ff == whi_ff);
   assign hit    = dv_ff && !word_full;
   assign do_fix = last_w && (op_ff == OP_REGION_FREE) && !fix_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (fill_end) state_in = ST_IDLE;
         ST_FILL:  if (fill_end) state_in = ST_DONE;
         ST_IDLE: begin
            if (cmd.start) begin
               case (cmd.op)
                  OP_INIT:        state_in = ST_FILL;
                  OP_ALLOC:       state_in = alloc_go ? ST_WALK : ST_DONE;
                  OP_FREE:        state_in = frame_ok ? ST_WALK : ST_DONE;
                  OP_REGION_FREE: state_in = ST_WALK;
                  OP_REGION_USED: state_in = region_go ? ST_WALK : ST_DONE;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            if (op_ff == OP_ALLOC) begin
               if (hit || last_w) state_in = ST_DONE;
            end else if (last_w && !do_fix) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE:  if (cmd.take) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in    = op_ff;
      issue_in = issue_ff;
      dv_in    = 1'b0;
      addr_in  = addr_ff;
      didx_in  = didx_ff;
      whi_in   = whi_ff;
      lo_in    = lo_ff;
      last_in  = last_ff;
      fix_in   = fix_ff;
      maxf_in  = maxf_ff;
      used_in  = used_ff;
      ok_in    = ok_ff;
      hit_in   = hit_ff;
      we       = 1'b0;
      waddr    = addr_ff;
      wdata    = '1;
      case (state_ff)
         ST_CLEAR: begin
            we      = 1'b1;
            addr_in = addr_ff + WIDX_W'(1);
         end
         ST_FILL: begin
            we      = 1'b1;
            addr_in = addr_ff + WIDX_W'(1);
            if (fill_end) used_in = maxf_ff;
         end
         ST_IDLE: begin
            if (cmd.start) begin
               op_in    = cmd.op;
               maxf_in  = cmd.max_frames;
               ok_in    = 1'b1;
               hit_in   = '0;
               fix_in   = 1'b0;
               addr_in  = '0;
               issue_in = 1'b0;
               case (cmd.op)
                  OP_ALLOC: begin
                     ok_in    = 1'b0;
                     issue_in = alloc_go;
                     whi_in   = WIDX_W'(words - COUNT_W'(1));
                  end
                  OP_FREE: begin
                     lo_in    = cmd.frame[FIDX_W-1:0];
                     last_in  = cmd.frame[FIDX_W-1:0];
                     whi_in   = cmd.frame[FIDX_W-1:BIT_W];
                     addr_in  = cmd.frame[FIDX_W-1:BIT_W];
                     issue_in = frame_ok;
                  end
                  OP_REGION_FREE, OP_REGION_USED: begin
                     if (region_go) begin
                        lo_in    = cmd.frame[FIDX_W-1:0];
                        last_in  = last_start;
                        whi_in   = last_start[FIDX_W-1:BIT_W];
                        addr_in  = cmd.frame[FIDX_W-1:BIT_W];
                        issue_in = 1'b1;
                     end else if (cmd.op == OP_REGION_FREE) begin
                        lo_in    = '0;
                        last_in  = '0;
                        whi_in   = '0;
                        issue_in = 1'b1;
                        fix_in   = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (issue_ff) begin
               dv_in   = 1'b1;
               didx_in = addr_ff;
               addr_in = addr_ff + WIDX_W'(1);
               if (addr_ff == whi_ff) issue_in = 1'b0;
            end
            if (dv_ff) begin
               waddr = didx_ff;
               if (op_ff == OP_ALLOC) begin
                  if (!word_full) begin
                     we       = 1'b1;
                     wdata    = rdata_ff | (WORD_BITS'(1) << zbit);
                     used_in  = used_ff + COUNT_W'(1);
                     ok_in    = 1'b1;
                     hit_in   = {didx_ff, zbit};
                     issue_in = 1'b0;
                     dv_in    = 1'b0;
                  end
               end else begin
                  we    = 1'b1;
                  wdata = set_mode ? (rdata_ff | mask) : (rdata_ff & ~mask);
                  if (!fix_ff) begin
                     if (set_mode) begin
                        if (used_ff < maxf_ff) begin
                           used_in = (up_sum > {1'b0, maxf_ff}) ? maxf_ff
                                                                : up_sum[COUNT_W-1:0];
                        end
                     end else begin
                        used_in = (used_ff > COUNT_W'(nbits))
                                ? used_ff - COUNT_W'(nbits) : '0;
                     end
                  end
                  if (do_fix) begin
                     lo_in    = '0;
                     last_in  = '0;
                     whi_in   = '0;
                     addr_in  = '0;
                     issue_in = 1'b1;
                     fix_in   = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         issue_ff <= 1'b0;
         dv_ff    <= 1'b0;
         addr_ff  <= '0;
         fix_ff   <= 1'b0;
         used_ff  <= '0;
         ok_ff    <= 1'b0;
         hit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         dv_ff    <= dv_in;
         addr_ff  <= addr_in;
         fix_ff   <= fix_in;
         used_ff  <= used_in;
         ok_ff    <= ok_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      didx_ff <= didx_in;
      whi_ff  <= whi_in;
      lo_ff   <= lo_in;
      last_ff <= last_in;
      maxf_ff <= maxf_in;
   end

   assign sts.idle  = state_ff == ST_IDLE;
   assign sts.done  = state_ff == ST_DONE;
   assign sts.ok    = ok_ff;
   assign sts.frame = hit_ff;
   assign sts.used  = used_ff;

endmodule

// ----- rtl/bitmap_page_frame_allocator.sv -----
`timescale 1ns / 1ps
// Top level of the bitmap page frame allocator: CSR port, request intake
// and response register. Depends on bpfa_pkg, bpfa_if and bpfa_engine.
//
//   port       dir   kind        carries
//   req_chan   in    valid/ready op, address, length
//   rsp_chan   out   valid/ready frame_address, ok, used_frames, free_frames
//   csr_*      in    APB         memory_size_kb at byte address 0
//
// One request at a time. Alloc reads map words in order until it finds a free
// bit, region ops walk the words of the region (region free then fixes frame 0).
// Init and reset each sweep all 1024 map words, one word per cycle; no request
// is taken during the reset sweep. The map memory port handles one word per
// cycle. A result waiting in rsp_chan holds the next finished
// request in the engine, and intake stops until the response is taken.
module bitmap_page_frame_allocator
   import bpfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bpfa_req_if.sink              req_chan,
   bpfa_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [KB_W-1:0]    kb_ff, kb_in;
   logic [COUNT_W-1:0] maxf;
   logic               csr_hit;
   cmd_type            cmd;
   sts_type            sts;
   logic               load;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0] rsp_used_ff, rsp_used_in;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_free_in;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == CSR_MEMORY_SIZE_KB;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(kb_ff) : '0;
   assign kb_in = (csr_psel && csr_penable && csr_pwrite && csr_hit)
                ? csr_pwdata[KB_W-1:0] : kb_ff;

   assign maxf = (kb_ff[KB_W-1:2] > COUNT_W'(NUM_FRAMES)) ? COUNT_W'(NUM_FRAMES)
                                                          : kb_ff[KB_W-1:2];

   assign req_chan.ready = sts.idle;
   assign load = sts.done && (!rsp_valid_ff || rsp_chan.ready);

   assign cmd.start      = req_chan.valid && req_chan.ready;
   assign cmd.take       = load;
   assign cmd.op         = op_type'(req_chan.op);
   assign cmd.frame      = req_chan.address[ADDR_W-1:FRAME_SHIFT];
   assign cmd.count      = req_chan.length[ADDR_W-1:FRAME_SHIFT];
   assign cmd.max_frames = maxf;

   bpfa_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_free_in  = rsp_free_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = ADDR_W'({sts.frame, {FRAME_SHIFT{1'b0}}});
         rsp_ok_in    = sts.ok;
         rsp_used_in  = sts.used;
         rsp_free_in  = (sts.used < maxf) ? maxf - sts.used : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kb_ff        <= kb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_used_ff <= rsp_used_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.frame_address = rsp_addr_ff;
   assign rsp_chan.ok            = rsp_ok_ff;
   assign rsp_chan.used_frames   = rsp_used_ff;
   assign rsp_chan.free_frames   = rsp_free_ff;

endmodule

// ----- test/tb_bitmap_page_frame_allocator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_page_frame_allocator: directed and random
// requests against an in-bench frame map tracker. Depends on bpfa_pkg and bpfa_if.
module tb_bitmap_page_frame_allocator
   import bpfa_pkg::*;
;

   localparam int RANDOM_ITEMS   = 1950;
   localparam int HOLD_OFF_LONG  = 400;
   localparam int SETTLE_CYCLES  = 1100;
   localparam int DRAIN_LIMIT    = 50000;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_KB_ADDR = {CSR_MEMORY_SIZE_KB, 2'b00};

   typedef struct packed {
      logic [ADDR_W-1:0]  frame_address;
      logic               ok;
      logic [COUNT_W-1:0] used_frames;
      logic [COUNT_W-1:0] free_frames;
   } alloc_reply_type;

   typedef enum {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_pace_type;

   class page_frame_tracker;
      bit [WORD_BITS-1:0] frame_bits [MAP_WORDS];
      int unsigned        frames_in_use;
      bit [KB_W-1:0]      size_kb;
      alloc_reply_type    pending_replies [$];

      function new();
         foreach (frame_bits[i]) frame_bits[i] = '1;
         frames_in_use = 0;
         size_kb = '0;
      endfunction

      function void set_size(bit [KB_W-1:0] kb);
         size_kb = kb;
      endfunction

      function int unsigned usable_frames();
         int unsigned m;
         m = size_kb / 4;
         return (m > NUM_FRAMES) ? NUM_FRAMES : m;
      endfunction

      function void bump_in_use();
         if (frames_in_use < usable_frames()) frames_in_use++;
      endfunction

      function void drop_in_use();
         if (frames_in_use > 0) frames_in_use--;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] address,
                                 logic [ADDR_W-1:0] length);
         int unsigned     start, count, limit, f;
         alloc_reply_type r;
         start = address >> FRAME_SHIFT;
         count = length >> FRAME_SHIFT;
         limit = usable_frames();
         r = '0;
         r.ok = 1'b1;
         case (op)
            OP_INIT: begin
               foreach (frame_bits[i]) frame_bits[i] = '1;
               frames_in_use = limit;
            end
            OP_ALLOC: begin
               r.ok = 1'b0;
               if (frames_in_use < limit) begin
                  for (int i = 0; i < limit / WORD_BITS && !r.ok; i++) begin
                     for (int j = 0; j < WORD_BITS && !r.ok; j++) begin
                        if (!frame_bits[i][j]) begin
                           frame_bits[i][j] = 1'b1;
                           bump_in_use();
                           r.frame_address = (i * WORD_BITS + j) << FRAME_SHIFT;
                           r.ok = 1'b1;
                        end
                     end
                  end
               end
            end
            OP_FREE: begin
               if (start < NUM_FRAMES) begin
                  frame_bits[start / WORD_BITS][start % WORD_BITS] = 1'b0;
                  drop_in_use();
               end
            end
            OP_REGION_FREE, OP_REGION_USED: begin
               for (int unsigned k = 0; k < count; k++) begin
                  f = start + k;
                  if (f >= NUM_FRAMES) break;
                  if (op == OP_REGION_FREE) begin
                     frame_bits[f / WORD_BITS][f % WORD_BITS] = 1'b0;
                     drop_in_use();
                  end else begin
                     frame_bits[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                     bump_in_use();
                  end
               end
               // frame 0 is always reserved after a region free
               if (op == OP_REGION_FREE) frame_bits[0][0] = 1'b1;
            end
            default: ;
         endcase
         r.used_frames = frames_in_use[COUNT_W-1:0];
         r.free_frames = (frames_in_use < limit) ? COUNT_W'(limit - frames_in_use) : '0;
         pending_replies.push_back(r);
      endfunction

      function string check_reply(alloc_reply_type got);
         alloc_reply_type want;
         string           msg;
         if (pending_replies.size() == 0)
            return $sformatf("response with none outstanding: addr %h ok %b used %0d free %0d",
                             got.frame_address, got.ok, got.used_frames, got.free_frames);
         want = pending_replies.pop_front();
         msg = "";
         if (got.frame_address !== want.frame_address)
            msg = {msg, $sformatf(" frame_address %h want %h", got.frame_address,
                                  want.frame_address)};
         if (got.ok !== want.ok)
            msg = {msg, $sformatf(" ok %b want %b", got.ok, want.ok)};
         if (got.used_frames !== want.used_frames)
            msg = {msg, $sformatf(" used_frames %0d want %0d", got.used_frames,
                                  want.used_frames)};
         if (got.free_frames !== want.free_frames)
            msg = {msg, $sformatf(" free_frames %0d want %0d", got.free_frames,
                                  want.free_frames)};
         return msg;
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bpfa_req_if req_chan ();
   bpfa_rsp_if rsp_chan ();

   bitmap_page_frame_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   page_frame_tracker tracker;
   int                mismatch_count = 0;
   int                burst_left = 0;
   int                hold_off_cycles = 0;
   int                random_sent = 0;
   int                phase_items;
   int                drain_cycles;
   bit                first_phase;
   rx_pace_type       rx_pace = RX_STEADY;
   int                pace_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200000000;
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t:%s", $time, what);
   endtask

   always @(posedge clock) begin : watch_responses
      alloc_reply_type got;
      string           msg;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.frame_address = rsp_chan.frame_address;
         got.ok            = rsp_chan.ok;
         got.used_frames   = rsp_chan.used_frames;
         got.free_frames   = rsp_chan.free_frames;
         msg = tracker.check_reply(got);
         if (msg != "") report_mismatch(msg);
      end
   end

   // response back-pressure, with a long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else begin
            if (pace_left == 0) begin
               rx_pace = rx_pace_type'($urandom_range(0, 3));
               pace_left = $urandom_range(16, 200);
            end
            pace_left--;
            case (rx_pace)
               RX_STEADY:  rsp_chan.ready <= 1'b1;
               RX_MOSTLY:  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               RX_SPARSE:  rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               RX_PATTERN: rsp_chan.ready <= ((pace_left % 5) < 2);
               default:    rsp_chan.ready <= 1'b1;
            endcase
         end
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] address,
                               input logic [ADDR_W-1:0] length);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.op      <= op;
      req_chan.address <= address;
      req_chan.length  <= length;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      tracker.note_request(op, address, length);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   task automatic write_memory_size(input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_KB_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tracker.set_size(value[KB_W-1:0]);
      if (readback[KB_W-1:0] !== value[KB_W-1:0])
         report_mismatch($sformatf(" memory_size_kb read %h want %h",
                                   readback[KB_W-1:0], value[KB_W-1:0]));
   endtask

   task automatic resize(input logic [CSR_DATA_W-1:0] value);
      wait_for_results();
      write_memory_size(value);
   endtask

   task automatic run_directed();
      send_request(OP_ALLOC, 32'h0, 32'h0);
      resize(32'd512);
      send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_INIT, 32'h0, 32'h0);
      send_request(OP_ALLOC, 32'h0, 32'h0);
      send_request(OP_FREE, 32'h0000_5FFF, 32'h0);
      send_request(OP_FREE, 32'h0000_5ABC, 32'h0);
      send_request(OP_ALLOC, 32'h0, 32'h0);
      send_request(OP_REGION_FREE, 32'h0, 32'h0000_8FFF);
      send_request(OP_ALLOC, 32'h0, 32'h0);
      send_request(OP_REGION_FREE, 32'h0000_3000, 32'h0000_0FFF);
      send_request(OP_FREE, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_FREE, 32'h07FF_F000, 32'h0);
      send_request(OP_REGION_FREE, 32'h07FF_F123, 32'hFFFF_FFFF);
      send_request(OP_REGION_USED, 32'hFFFF_F000, 32'hFFFF_FFFF);
      for (int s = OP_SPARE_FIRST; s < 2 ** OP_W; s++)
         send_request(s[OP_W-1:0], $urandom, $urandom);
      send_request(OP_REGION_USED, 32'h0, 32'hFFFF_FFFF);
      // shrink below the count already in use
      resize(32'd256);
      send_request(OP_ALLOC, 32'h0, 32'h0);
      send_request(OP_REGION_USED, 32'h0000_1000, 32'h0000_2000);
      // trailing partial word is never handed out
      resize(32'd160);
      send_request(OP_INIT, 32'h0, 32'h0);
      send_request(OP_REGION_FREE, 32'h0002_0000, 32'h0000_8000);
      send_request(OP_ALLOC, 32'h0, 32'h0);
      resize(($urandom << KB_W) | 32'h3FFFF);
      send_request(OP_INIT, 32'h0, 32'h0);
      send_request(OP_FREE, 32'h07FF_FFFF, 32'h0);
      send_request(OP_ALLOC, 32'h0, 32'h0);
      resize(32'd131072);
      send_request(OP_ALLOC, 32'h0, 32'h0);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_memory_size();
      logic [KB_W-1:0] kb;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: kb = '0;
               1: kb = KB_W'(4);
               2: kb = KB_W'(131072);
               default: kb = '1;
            endcase
         end
         1: kb = KB_W'($urandom_range(2048, 131072));
         2, 3: kb = KB_W'($urandom_range(1, 16) * 128);
         default: kb = KB_W'($urandom_range(0, 2048));
      endcase
      return ($urandom << KB_W) | kb;
   endfunction

   task automatic send_random_request();
      int unsigned     span, frame, run, roll;
      logic [11:0]     low_a, low_l;
      logic [ADDR_W-1:0] address, length;
      span  = tracker.usable_frames() + 64;
      frame = $urandom_range(0, span - 1);
      run   = ($urandom_range(0, 29) == 0) ? 32'hFFFFF : $urandom_range(0, 48);
      low_a = 12'($urandom_range(0, 4095));
      low_l = 12'($urandom_range(0, 4095));
      address = {frame[ADDR_W-FRAME_SHIFT-1:0], low_a};
      length  = {run[ADDR_W-FRAME_SHIFT-1:0], low_l};
      roll = $urandom_range(0, 99);
      if (roll < 3)
         send_request(OP_INIT, $urandom, $urandom);
      else if (roll < 40)
         send_request(OP_ALLOC, $urandom, $urandom);
      else if (roll < 62)
         send_request(OP_FREE, address, $urandom);
      else if (roll < 74)
         send_request(OP_REGION_FREE, address, length);
      else if (roll < 86)
         send_request(OP_REGION_USED, address, length);
      else
         send_request(OP_W'($urandom_range(0, 7)), $urandom, $urandom);
   endtask

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.op      <= '0;
      req_chan.address <= '0;
      req_chan.length  <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      first_phase = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         resize(pick_memory_size());
         if ($urandom_range(0, 9) < 7) begin
            send_request(OP_INIT, $urandom, $urandom);
            random_sent++;
         end
         phase_items = (tracker.usable_frames() > 4096) ? $urandom_range(8, 20)
                                                         : $urandom_range(30, 90);
         for (int i = 0; i < phase_items; i++) begin
            if (i == 5 && (first_phase || $urandom_range(0, 9) == 0))
               hold_off_cycles = HOLD_OFF_LONG;
            send_random_request();
            random_sent++;
         end
         first_phase = 1'b0;
      end

      req_chan.valid <= 1'b0;
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (tracker.pending() != 0 && drain_cycles < DRAIN_LIMIT);
      if (tracker.pending() != 0)
         report_mismatch($sformatf(" %0d responses never arrived", tracker.pending()));
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
